@@ rtl/hcicg_pkg.sv @@
`default_nettype none

package hcicg_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W = (CNT_W > 8) ? CNT_W : 8;

    // Packet codes.
    localparam logic [7:0] PTYPE_COMMAND    = 8'h01;
    localparam logic [7:0] PTYPE_EVENT      = 8'h04;
    localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
    localparam logic [7:0] EVT_CMD_STATUS   = 8'h0F;
    localparam logic       OP_HOST          = 1'b0;
    localparam logic       DEST_CONTROLLER  = 1'b0;
    localparam logic       DEST_HOST        = 1'b1;

    typedef struct packed {
        logic        operation;
        logic        packet_empty;
        logic [7:0]  packet_type;
        logic [7:0]  evt_code;
        logic        header_ok;
        logic [7:0]  credit_count;
        logic [15:0] packet_handle;
    } in_item_t;

    typedef struct packed {
        logic        destination;
        logic [15:0] out_handle;
        logic        dropped;
        logic        credit_rewritten;
        logic [7:0]  credit_value;
        logic        last;
    } out_item_t;

    // Which result the datapath loads into its output register.
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_FORWARD,
        OUT_DROP,
        OUT_EVENT,
        OUT_DRAINED
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     push;
        logic     pop;
        logic     credit_dec;
        logic     credit_load;
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_empty;
        logic item_host;
        logic item_command;
        logic credit_event;
        logic queue_empty;
        logic queue_full;
        logic credit_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/hcicg_ctrl.sv @@
`default_nettype none

module hcicg_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcicg_pkg::dp_status_t status,
    output hcicg_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DRAIN,
        ST_DRAIN_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.out_sel     = hcicg_pkg::OUT_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.item_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.item_host)
                begin
                    if (!status.item_command)
                    begin
                        if (status.out_free)
                        begin
                            cmd.out_sel = hcicg_pkg::OUT_FORWARD;
                            state_next  = ST_IDLE;
                        end
                    end
                    else if (status.queue_empty && !status.credit_zero)
                    begin
                        if (status.out_free)
                        begin
                            cmd.out_sel    = hcicg_pkg::OUT_FORWARD;
                            cmd.credit_dec = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    else if (status.queue_full)
                    begin
                        if (status.out_free)
                        begin
                            cmd.out_sel = hcicg_pkg::OUT_DROP;
                            state_next  = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (status.credit_event)
                begin
                    cmd.credit_load = 1'b1;
                    state_next      = ST_DRAIN;
                end
                else if (status.out_free)
                begin
                    cmd.out_sel = hcicg_pkg::OUT_FORWARD;
                    state_next  = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (!status.queue_empty && !status.credit_zero)
                begin
                    cmd.pop        = 1'b1;
                    cmd.credit_dec = 1'b1;
                    state_next     = ST_DRAIN_LOAD;
                end
                else if (status.out_free)
                begin
                    cmd.out_sel = hcicg_pkg::OUT_EVENT;
                    state_next  = ST_IDLE;
                end
            end
            ST_DRAIN_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_sel = hcicg_pkg::OUT_DRAINED;
                    state_next  = ST_DRAIN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/hcicg_datapath.sv @@
`default_nettype none

module hcicg_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hcicg_pkg::in_item_t  in_data,
    input  wire hcicg_pkg::ctrl_cmd_t cmd,
    output hcicg_pkg::dp_status_t     status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hcicg_pkg::out_item_t      out_data
);

    localparam int PW = hcicg_pkg::PTR_W;
    localparam int CW = hcicg_pkg::CNT_W;
    localparam int AW = hcicg_pkg::CAP_W;

    hcicg_pkg::in_item_t  item_reg;
    hcicg_pkg::out_item_t out_data_reg;
    hcicg_pkg::out_item_t out_data_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           credit_reg;
    logic [7:0]           credit_next;
    logic [PW-1:0]        head_reg;
    logic [PW-1:0]        head_next;
    logic [PW-1:0]        tail_reg;
    logic [PW-1:0]        tail_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [15:0]          queue_mem_reg [hcicg_pkg::QUEUE_DEPTH];
    logic [15:0]          rdata_reg;
    logic [AW-1:0]        free_space;
    logic [7:0]           free_capped;
    logic                 load;

    // Pointer advance with wrap at the queue depth.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(hcicg_pkg::QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    // Classification of the held item and queue status.
    always_comb
    begin
        status.item_empty   = item_reg.packet_empty;
        status.item_host    = (item_reg.operation == hcicg_pkg::OP_HOST);
        status.item_command = (item_reg.packet_type == hcicg_pkg::PTYPE_COMMAND);
        status.credit_event = (item_reg.packet_type == hcicg_pkg::PTYPE_EVENT)
                              && item_reg.header_ok
                              && ((item_reg.evt_code == hcicg_pkg::EVT_CMD_COMPLETE)
                                  || (item_reg.evt_code == hcicg_pkg::EVT_CMD_STATUS));
        status.queue_empty  = (count_reg == '0);
        status.queue_full   = (count_reg >= CW'(hcicg_pkg::QUEUE_DEPTH));
        status.credit_zero  = (credit_reg == 8'd0);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // Free queue space, capped to fit the credit field.
    always_comb
    begin
        free_space = AW'(hcicg_pkg::QUEUE_DEPTH) - AW'(count_reg);
        if (free_space > AW'(255))
        begin
            free_capped = 8'hFF;
        end
        else
        begin
            free_capped = free_space[7:0];
        end
    end

    // Credit counter and queue pointers.
    always_comb
    begin
        credit_next = credit_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        if (cmd.credit_load)
        begin
            credit_next = item_reg.credit_count;
        end
        else if (cmd.credit_dec)
        begin
            credit_next = credit_reg - 8'd1;
        end
        if (cmd.push)
        begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - CW'(1);
        end
    end

    // Result selection for the output register.
    always_comb
    begin
        load          = (cmd.out_sel != hcicg_pkg::OUT_NONE);
        out_data_next = '0;
        case (cmd.out_sel)
            hcicg_pkg::OUT_FORWARD:
            begin
                out_data_next.destination = (item_reg.operation == hcicg_pkg::OP_HOST)
                                            ? hcicg_pkg::DEST_CONTROLLER
                                            : hcicg_pkg::DEST_HOST;
                out_data_next.out_handle  = item_reg.packet_handle;
                out_data_next.last        = 1'b1;
            end
            hcicg_pkg::OUT_DROP:
            begin
                out_data_next.destination = hcicg_pkg::DEST_CONTROLLER;
                out_data_next.out_handle  = item_reg.packet_handle;
                out_data_next.dropped     = 1'b1;
                out_data_next.last        = 1'b1;
            end
            hcicg_pkg::OUT_EVENT:
            begin
                out_data_next.destination = hcicg_pkg::DEST_HOST;
                out_data_next.out_handle  = item_reg.packet_handle;
                out_data_next.last        = 1'b1;
                if (free_capped > item_reg.credit_count)
                begin
                    out_data_next.credit_rewritten = 1'b1;
                    out_data_next.credit_value     = free_capped;
                end
                else
                begin
                    out_data_next.credit_value = item_reg.credit_count;
                end
            end
            hcicg_pkg::OUT_DRAINED:
            begin
                out_data_next.destination = hcicg_pkg::DEST_CONTROLLER;
                out_data_next.out_handle  = rdata_reg;
            end
            default:
            begin
                out_data_next = '0;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg    <= credit_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Command queue memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            queue_mem_reg[tail_reg] <= item_reg.packet_handle;
        end
        if (cmd.pop)
        begin
            rdata_reg <= queue_mem_reg[head_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/hci_command_credit_gate.sv @@
`default_nettype none

// Routes HCI packets between host and controller and holds host commands back
// until the controller grants command credits. Each packet item is taken in the
// idle state and decided in the decide state; the next item is accepted while
// a result still waits in the output register. A Command Complete or Command
// Status event drains the command queue, as far as the granted credits allow,
// through its single read port, one pop and one result load per drained command,
// then loads the event result, for up to the queue depth of 32 drained commands.
// Results stall while out_ready is low. The queue needs no clearing after reset.
module hci_command_credit_gate (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hcicg_pkg::in_item_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hcicg_pkg::out_item_t     out_data
);

    hcicg_pkg::ctrl_cmd_t  cmd;
    hcicg_pkg::dp_status_t status;

    // Sequencer.
    hcicg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Credits, queue and result register.
    hcicg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ sim/hcicg_route_checker.sv @@
`default_nettype none

// Watches both item channels of the credit gate, keeps its own copy of the
// command credits and the held command queue, and compares every result
// that leaves the block against the oldest expected one.
module hcicg_route_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire hcicg_pkg::in_item_t  in_data,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire hcicg_pkg::out_item_t out_data,
    output int                        failures,
    output int                        pending
);

    logic [7:0]           credits_left = '0;
    logic [15:0]          held_handles[$];
    hcicg_pkg::out_item_t expected_routes[$];
    int                   mismatches = 0;
    int                   awaited = 0;

    assign failures = mismatches;
    assign pending = awaited;

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // Appends one result to the expected order.
    task automatic add_route(input hcicg_pkg::out_item_t r);
        expected_routes.insert(expected_routes.size(), r);
    endtask

    // Works out the results that one accepted packet item causes and
    // updates the credit counter and the held command queue.
    task automatic route_packet(input hcicg_pkg::in_item_t pkt);
        hcicg_pkg::out_item_t res;
        int                   room;
        res = '0;
        res.out_handle = pkt.packet_handle;
        res.last = 1'b1;
        if (!pkt.packet_empty)
        begin
            if (pkt.operation == hcicg_pkg::OP_HOST)
            begin
                res.destination = hcicg_pkg::DEST_CONTROLLER;
                if (pkt.packet_type != hcicg_pkg::PTYPE_COMMAND)
                begin
                    add_route(res);
                end
                else if (held_handles.size() == 0 && credits_left != 8'd0)
                begin
                    credits_left--;
                    add_route(res);
                end
                else if (held_handles.size() >= hcicg_pkg::QUEUE_DEPTH)
                begin
                    res.dropped = 1'b1;
                    add_route(res);
                end
                else
                begin
                    held_handles.insert(held_handles.size(), pkt.packet_handle);
                end
            end
            else if (pkt.packet_type == hcicg_pkg::PTYPE_EVENT && pkt.header_ok &&
                     (pkt.evt_code == hcicg_pkg::EVT_CMD_COMPLETE ||
                      pkt.evt_code == hcicg_pkg::EVT_CMD_STATUS))
            begin
                // Load the granted credits and release held commands in order.
                credits_left = pkt.credit_count;
                while (held_handles.size() > 0 && credits_left != 8'd0)
                begin
                    credits_left--;
                    res.destination = hcicg_pkg::DEST_CONTROLLER;
                    res.out_handle = held_handles[0];
                    held_handles.delete(0);
                    res.last = 1'b0;
                    add_route(res);
                end
                // The credit field is raised to the free queue space if larger.
                room = hcicg_pkg::QUEUE_DEPTH - held_handles.size();
                if (room > 255)
                    room = 255;
                res.destination = hcicg_pkg::DEST_HOST;
                res.out_handle = pkt.packet_handle;
                res.last = 1'b1;
                res.credit_value = pkt.credit_count;
                if (room > int'(pkt.credit_count))
                begin
                    res.credit_rewritten = 1'b1;
                    res.credit_value = room[7:0];
                end
                add_route(res);
            end
            else
            begin
                res.destination = hcicg_pkg::DEST_HOST;
                add_route(res);
            end
        end
    endtask

    // Results are checked before the item accepted at the same edge is
    // predicted, so a result can never match its own input early.
    always @(posedge clk)
    begin : watch
        hcicg_pkg::out_item_t want;
        if (!rst_n)
        begin
            credits_left = '0;
            held_handles.delete();
            expected_routes.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_routes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_routes[0];
                    expected_routes.delete(0);
                    compare_field("destination", 16'(want.destination),
                                  16'(out_data.destination));
                    compare_field("out_handle", want.out_handle, out_data.out_handle);
                    compare_field("dropped", 16'(want.dropped), 16'(out_data.dropped));
                    compare_field("credit_rewritten", 16'(want.credit_rewritten),
                                  16'(out_data.credit_rewritten));
                    compare_field("credit_value", 16'(want.credit_value),
                                  16'(out_data.credit_value));
                    compare_field("last", 16'(want.last), 16'(out_data.last));
                end
            end
            if (in_valid && in_ready)
                route_packet(in_data);
        end
        awaited <= expected_routes.size();
    end

endmodule

`default_nettype wire

@@ sim/hci_command_credit_gate_test.sv @@
`default_nettype none

// Drives packet items into the credit gate with random gaps and random
// result back-pressure; the checker beside the block does all comparing.
module hci_command_credit_gate_test;

    localparam int   CYCLE = 12;
    localparam int   RUN_ITEMS = 90;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN_MARGIN = 80;
    localparam int   LIMIT_CYCLES = 2000000;
    localparam logic OP_CONTROLLER = ~hcicg_pkg::OP_HOST;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid;
    logic                 in_ready;
    hcicg_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_ready;
    hcicg_pkg::out_item_t out_data;
    int                   failures;
    int                   pending;

    logic                 calm = 1'b0;
    logic                 no_gaps = 1'b0;
    logic                 hold_wanted = 1'b0;
    logic                 hold_active = 1'b0;
    int                   sent_items = 0;

    hci_command_credit_gate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    hcicg_route_checker route_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .failures  (failures),
        .pending   (pending)
    );

    always
    begin
        #(CYCLE / 2) clk = 1'b1;
        #(CYCLE / 2) clk = 1'b0;
    end

    initial
    begin
        #(CYCLE * LIMIT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    function automatic hcicg_pkg::in_item_t make_packet(input logic op,
                                                        input logic [7:0] ptype,
                                                        input logic [7:0] code,
                                                        input logic ok,
                                                        input logic [7:0] credits,
                                                        input logic [15:0] handle);
        hcicg_pkg::in_item_t pkt;
        pkt.operation = op;
        pkt.packet_empty = 1'b0;
        pkt.packet_type = ptype;
        pkt.evt_code = code;
        pkt.header_ok = ok;
        pkt.credit_count = credits;
        pkt.packet_handle = handle;
        return pkt;
    endfunction

    function automatic hcicg_pkg::in_item_t random_packet();
        return make_packet(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                           8'($urandom), 16'($urandom));
    endfunction

    function automatic logic [7:0] credit_code();
        return ($urandom_range(0, 1) == 0) ? hcicg_pkg::EVT_CMD_COMPLETE
                                           : hcicg_pkg::EVT_CMD_STATUS;
    endfunction

    function automatic hcicg_pkg::in_item_t host_command();
        return make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_COMMAND, 8'($urandom),
                           1'($urandom), 8'($urandom), 16'($urandom));
    endfunction

    function automatic hcicg_pkg::in_item_t credit_event(input logic [7:0] credits);
        return make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT, credit_code(), 1'b1,
                           credits, 16'($urandom));
    endfunction

    // Offers one item, holds it until accepted, then maybe idles a while.
    task automatic send(input hcicg_pkg::in_item_t pkt);
        in_valid <= 1'b1;
        in_data <= pkt;
        do
            @(posedge clk);
        while (!in_ready);
        if (!pkt.packet_empty)
            sent_items++;
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Stops offering until every expected result has left the block.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Starves the credit counter, fills the command queue to or past its depth so
    // that commands may be dropped, then grants enough credits to drain it all.
    task automatic fill_queue();
        send(credit_event(8'd0));
        repeat ($urandom_range(hcicg_pkg::QUEUE_DEPTH, hcicg_pkg::QUEUE_DEPTH + 3))
            send(host_command());
        if ($urandom_range(0, 1) == 0)
            send(credit_event(8'd0));
        send(credit_event(8'($urandom_range(hcicg_pkg::QUEUE_DEPTH, 255))));
    endtask

    // Holds results back for a long stretch while items keep coming, so the
    // block backs up and stalls its input, then waits for everything to drain.
    task automatic stall_burst();
        no_gaps = 1'b1;
        send(credit_event(8'd0));
        repeat (4) send(host_command());
        in_valid <= 1'b0;
        hold_wanted = 1'b1;
        while (!hold_active) @(posedge clk);
        repeat (10) send(make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_EVENT,
                                     8'($urandom), 1'($urandom), 8'($urandom),
                                     16'($urandom)));
        send(credit_event(8'd200));
        repeat (10) send(make_packet(OP_CONTROLLER, 8'($urandom), 8'($urandom),
                                     1'($urandom), 8'($urandom), 16'($urandom)));
        settle();
        no_gaps = calm;
    endtask

    // Result side: random ready bursts, one long hold on request, none at the end.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        hcicg_pkg::in_item_t pkt;
        int                  kind;
        logic                stalled_once;
        stalled_once = 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items: empty packets, routing of each kind, credit edges.
        pkt = make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_COMMAND, 8'hFF, 1'b1,
                          8'hFF, 16'hFFFF);
        pkt.packet_empty = 1'b1;
        send(pkt);
        send(make_packet(hcicg_pkg::OP_HOST, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000));
        send(make_packet(hcicg_pkg::OP_HOST, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF));
        send(make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_COMMAND, 8'h00, 1'b0,
                         8'h00, 16'h1234));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                         hcicg_pkg::EVT_CMD_COMPLETE, 1'b0, 8'd5, 16'h00A5));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT, 8'hFF, 1'b1, 8'd9,
                         16'h5A5A));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_COMMAND,
                         hcicg_pkg::EVT_CMD_COMPLETE, 1'b1, 8'd9, 16'hA5A5));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                         hcicg_pkg::EVT_CMD_STATUS, 1'b1, 8'd0, 16'h0F0F));
        send(make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_COMMAND, 8'h00, 1'b0,
                         8'h00, 16'h0001));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                         hcicg_pkg::EVT_CMD_COMPLETE, 1'b1, 8'd1, 16'hF0F0));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                         hcicg_pkg::EVT_CMD_COMPLETE, 1'b1, 8'd255, 16'h8000));
        send(make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_COMMAND, 8'h00, 1'b0,
                         8'h00, 16'hFFFF));
        send(make_packet(hcicg_pkg::OP_HOST, hcicg_pkg::PTYPE_COMMAND, 8'h00, 1'b0,
                         8'h00, 16'h0000));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                         hcicg_pkg::EVT_CMD_STATUS, 1'b1, 8'(hcicg_pkg::QUEUE_DEPTH),
                         16'h0101));
        send(make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                         hcicg_pkg::EVT_CMD_STATUS, 1'b1,
                         8'(hcicg_pkg::QUEUE_DEPTH - 1), 16'h0202));
        pkt = make_packet(OP_CONTROLLER, hcicg_pkg::PTYPE_EVENT,
                          hcicg_pkg::EVT_CMD_COMPLETE, 1'b1, 8'd255, 16'h7FFF);
        pkt.packet_empty = 1'b1;
        send(pkt);
        send(make_packet(OP_CONTROLLER, 8'hFF, hcicg_pkg::EVT_CMD_STATUS, 1'b1, 8'hFF,
                         16'hFFFE));
        settle();

        // Random items, mostly well-formed command and credit traffic.
        sent_items = 0;
        fill_queue();
        while (sent_items < RUN_ITEMS)
        begin
            if (!stalled_once && sent_items >= 40)
            begin
                stall_burst();
                stalled_once = 1'b1;
            end
            if (sent_items >= RUN_ITEMS - 20)
            begin
                calm = 1'b1;
                no_gaps = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                send(host_command());
            end
            else if (kind < 60)
            begin
                if ($urandom_range(0, 9) < 7)
                    send(credit_event(8'($urandom_range(0, 3))));
                else
                    send(credit_event(8'($urandom)));
            end
            else if (kind < 70)
            begin
                pkt = random_packet();
                pkt.operation = hcicg_pkg::OP_HOST;
                send(pkt);
            end
            else if (kind < 80)
            begin
                pkt = random_packet();
                pkt.operation = OP_CONTROLLER;
                send(pkt);
            end
            else if (kind < 85)
            begin
                pkt = credit_event(8'($urandom));
                pkt.header_ok = 1'b0;
                send(pkt);
            end
            else if (kind < 90)
            begin
                pkt = random_packet();
                pkt.packet_empty = 1'b1;
                send(pkt);
            end
            else if (kind < 94)
            begin
                fill_queue();
            end
            else
            begin
                pkt = credit_event(8'($urandom));
                pkt.evt_code = 8'($urandom);
                send(pkt);
            end
        end

        settle();
        repeat (DRAIN_MARGIN) @(posedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
